FILE: rtl/gcq_pkg.sv
`timescale 1ns / 1ps
package gcq_pkg;
	localparam int MAX_GRID = 64;
	localparam int COORD_BITS = 24;
	localparam int IDX_W = 6;
	localparam int CS_W = 16;
	localparam int GC_W = 7;
	localparam int W2 = 34;
	localparam int QW = 26;
	localparam int REG_CELL_SIZE = 0;
	localparam int REG_GRID_COUNT = 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SETUP, ST_DIV, ST_CLAMP, ST_ROW, ST_CELL, ST_SQ, ST_CMP, ST_EMIT, ST_INV
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic div_step;
		logic clamp;
		logic row_init;
		logic col_test;
		logic sq;
		logic cmp;
		logic next_col;
		logic next_row;
		logic emit;
		logic emit_inv;
	} cmd_t;

	typedef struct packed {
		logic no_grid;
		logic div_done;
		logic col_last;
		logic row_last;
	} sts_t;
endpackage

FILE: rtl/gcq_ctrl.sv
`timescale 1ns / 1ps
module gcq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output gcq_pkg::cmd_t cmd,
	input  gcq_pkg::sts_t sts
);
	import gcq_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_nx = ST_SETUP;
			ST_SETUP: state_nx = sts.no_grid ? ST_INV : ST_DIV;
			ST_DIV:   if (sts.div_done) state_nx = ST_CLAMP;
			ST_CLAMP: state_nx = ST_ROW;
			ST_ROW:   state_nx = ST_CELL;
			ST_CELL:  state_nx = ST_SQ;
			ST_SQ:    state_nx = ST_CMP;
			ST_CMP:   state_nx = sts.col_last ? ST_EMIT : ST_CELL;
			ST_EMIT:  state_nx = sts.row_last ? ST_IDLE : ST_ROW;
			ST_INV:   state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE:  cmd.load = start;
			ST_SETUP: cmd.setup = 1'b1;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_CLAMP: cmd.clamp = 1'b1;
			ST_ROW:   cmd.row_init = 1'b1;
			ST_CELL:  cmd.col_test = 1'b1;
			ST_SQ:    cmd.sq = 1'b1;
			ST_CMP: begin
				cmd.cmp = 1'b1;
				cmd.next_col = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				cmd.next_row = 1'b1;
			end
			ST_INV:   cmd.emit_inv = 1'b1;
			default:  cmd = '0;
		endcase
	end

	ap_inv: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SETUP && sts.no_grid |=> state_q == ST_INV) else $error("inv path");
	ap_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE && start |=> state_q == ST_SETUP) else $error("start lost");
	ap_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP && sts.col_last |=> state_q == ST_EMIT) else $error("emit");
endmodule

FILE: rtl/gcq_dp.sv
`timescale 1ns / 1ps
module gcq_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [0:0]                         cfg_index,
	input  logic [15:0]                        cfg_data,
	input  logic signed [gcq_pkg::COORD_BITS-1:0] center_x,
	input  logic signed [gcq_pkg::COORD_BITS-1:0] center_y,
	input  logic signed [gcq_pkg::COORD_BITS-1:0] radius,
	input  gcq_pkg::cmd_t                      cmd,
	output gcq_pkg::sts_t                      sts,
	output logic                               result_valid,
	output logic [5:0]                         row_index,
	output logic [63:0]                        column_hits,
	output logic                               last_row,
	output logic                               grid_invalid
);
	import gcq_pkg::*;

	logic [CS_W-1:0] cs_q;
	logic [GC_W-1:0] gc_q;
	logic signed [W2-1:0] cx_q, cy_q, r_q, org_q, span_q;
	logic [IDX_W:0] n_q;
	// four numerators divided together, restoring, one quotient bit per cycle
	logic signed [W2-1:0] num_q [4];
	logic [W2-1:0] rem_q [4];
	logic [QW-1:0] quo_q [4];
	logic [4:0] dcnt_q;
	logic [IDX_W-1:0] maxx_q, miny_q, maxy_q, i_q, j_q;
	logic signed [W2-1:0] lox_q, ly_q;
	logic [W2-1:0] dx_q, dy_q;
	logic [2*COORD_BITS-1:0] dxx_q, dyy_q, rr_q;
	logic skip_q;
	logic [63:0] hits_q;
	logic [QW-1:0] qf [4];
	logic [IDX_W-1:0] ci [4];
	logic [W2-1:0] rsh [4];
	logic signed [W2-1:0] hix, qx, hiy, qy, dxs, dys;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q <= CS_W'(100);
			gc_q <= GC_W'(16);
		end else if (cfg_we) begin
			if (cfg_index == 1'(REG_CELL_SIZE)) cs_q <= cfg_data;
			else gc_q <= cfg_data[GC_W-1:0];
		end
	end

	assign sts.no_grid = (gc_q == '0) || (cs_q == '0);
	assign sts.div_done = (dcnt_q == 5'(QW));
	assign sts.col_last = (j_q == maxy_q);
	assign sts.row_last = (i_q == maxx_q);

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			qf[k] = quo_q[k];
			// floor: negative numerator -> clamp to 0 anyway
			if (num_q[k] < 0) ci[k] = '0;
			else begin
				if (qf[k] > QW'(n_q - 1'b1)) ci[k] = IDX_W'(n_q - 1'b1);
				else ci[k] = qf[k][IDX_W-1:0];
			end
			rsh[k] = {rem_q[k][W2-2:0], quo_q[k][QW-1]};
		end
		hix = lox_q + span_q;
		qx = (cx_q < lox_q) ? lox_q : ((cx_q > hix) ? hix : cx_q);
		dxs = qx - cx_q;
		hiy = ly_q + span_q;
		qy = (cy_q < ly_q) ? ly_q : ((cy_q > hiy) ? hiy : cy_q);
		dys = qy - cy_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q <= W2'(center_x) <<< 1;
			cy_q <= W2'(center_y) <<< 1;
			r_q <= (radius < 0) ? '0 : (W2'(radius) <<< 1);
			n_q <= (gc_q > GC_W'(MAX_GRID)) ? (IDX_W+1)'(MAX_GRID) : gc_q;
		end
		if (cmd.setup) begin
			org_q <= W2'(cs_q) * W2'(n_q);
			span_q <= W2'({cs_q, 1'b0});
			num_q[0] <= cx_q - r_q + W2'(cs_q) * W2'(n_q);
			num_q[1] <= cx_q + r_q + W2'(cs_q) * W2'(n_q);
			num_q[2] <= cy_q - r_q + W2'(cs_q) * W2'(n_q);
			num_q[3] <= cy_q + r_q + W2'(cs_q) * W2'(n_q);
			for (int k = 0; k < 4; k++) rem_q[k] <= '0;
			dcnt_q <= '0;
		end
		if (cmd.setup) begin
			for (int k = 0; k < 4; k++) quo_q[k] <= QW'(cx_q - cx_q);
		end
		if (cmd.div_step) begin
			for (int k = 0; k < 4; k++) begin
				if (dcnt_q == '0) begin
					rem_q[k] <= '0;
					quo_q[k] <= num_q[k][QW-1:0];
				end else if (rsh[k] >= span_q) begin
					rem_q[k] <= rsh[k] - span_q;
					quo_q[k] <= {quo_q[k][QW-2:0], 1'b1};
				end else begin
					rem_q[k] <= rsh[k];
					quo_q[k] <= {quo_q[k][QW-2:0], 1'b0};
				end
			end
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.clamp) begin
			maxx_q <= ci[1];
			miny_q <= ci[2];
			maxy_q <= ci[3];
			i_q <= ci[0];
			lox_q <= W2'(ci[0]) * span_q - org_q;
		end
		if (cmd.row_init) begin
			j_q <= miny_q;
			ly_q <= W2'(miny_q) * span_q - org_q;
			hits_q <= '0;
			dx_q <= (dxs < 0) ? W2'(-dxs) : W2'(dxs);
		end
		if (cmd.col_test) begin
			dy_q <= (dys < 0) ? W2'(-dys) : W2'(dys);
		end
		if (cmd.sq) begin
			skip_q <= (dx_q > r_q) || (dy_q > r_q);
			dxx_q <= dx_q[COORD_BITS-1:0] * dx_q[COORD_BITS-1:0];
			dyy_q <= dy_q[COORD_BITS-1:0] * dy_q[COORD_BITS-1:0];
			rr_q <= r_q[COORD_BITS-1:0] * r_q[COORD_BITS-1:0];
		end
		if (cmd.cmp) begin
			if (!skip_q && ({1'b0, dxx_q} + {1'b0, dyy_q} <= {1'b0, rr_q}))
				hits_q[j_q] <= 1'b1;
			j_q <= j_q + 1'b1;
			ly_q <= ly_q + span_q;
		end
		if (cmd.emit) begin
			i_q <= i_q + 1'b1;
			lox_q <= lox_q + span_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= cmd.emit || cmd.emit_inv;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			row_index <= i_q;
			column_hits <= hits_q;
			last_row <= sts.row_last;
			grid_invalid <= 1'b0;
		end else if (cmd.emit_inv) begin
			row_index <= '0;
			column_hits <= '0;
			last_row <= 1'b1;
			grid_invalid <= 1'b1;
		end
	end
endmodule

FILE: rtl/grid_circle_cell_query.sv
`timescale 1ns / 1ps
// channel   | ports                                          | handshake
// query     | center_x, center_y, radius                     | start & !busy
// config    | cfg_we, cfg_index, cfg_data                    | cfg_we
// row out   | row_index, column_hits, last_row, grid_invalid | result_valid
// A query runs setup, the serial floor divider and the clamp, then for each row of the clamped
// box a row start, one cell test per column (cell, square, compare) and a row emit.
// No-grid query: one result, flagged grid_invalid. Reset is async, active low.
// Results are strobed for one cycle; the receiver cannot stall.
module grid_circle_cell_query (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [gcq_pkg::COORD_BITS-1:0] center_x,
	input  logic signed [gcq_pkg::COORD_BITS-1:0] center_y,
	input  logic signed [gcq_pkg::COORD_BITS-1:0] radius,
	input  logic                               cfg_we,
	input  logic [0:0]                         cfg_index,
	input  logic [15:0]                        cfg_data,
	output logic                               result_valid,
	output logic [5:0]                         row_index,
	output logic [63:0]                        column_hits,
	output logic                               last_row,
	output logic                               grid_invalid
);
	import gcq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	gcq_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .sts(sts));

	gcq_dp u_dp (.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .center_x(center_x), .center_y(center_y), .radius(radius),
		.cmd(cmd), .sts(sts), .result_valid(result_valid), .row_index(row_index),
		.column_hits(column_hits), .last_row(last_row), .grid_invalid(grid_invalid));
endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import gcq_pkg::*;

	localparam longint CYCLE_LIMIT = 30000000;
	localparam int SETTLE = 40;

	typedef enum int {OP_QUERY, OP_REG_WRITE, OP_DRAIN} op_t;

	typedef struct {
		op_t kind;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic signed [COORD_BITS-1:0] rad;
		int idle_pct;
		logic [0:0] reg_idx;
		logic [15:0] reg_data;
	} request_t;

	typedef struct {
		logic [5:0] row;
		logic [63:0] hits;
		logic last;
		logic inv;
	} row_result_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [COORD_BITS-1:0] center_x;
	logic signed [COORD_BITS-1:0] center_y;
	logic signed [COORD_BITS-1:0] radius;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [15:0] cfg_data;
	logic result_valid;
	logic [5:0] row_index;
	logic [63:0] column_hits;
	logic last_row;
	logic grid_invalid;

	request_t pending_requests[$];
	row_result_t expected_rows[$];
	longint model_cell_size;
	longint model_grid_count;
	int errors;
	int quiet_cycles;
	longint cycles;

	grid_circle_cell_query dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.center_x(center_x),
		.center_y(center_y),
		.radius(radius),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.row_index(row_index),
		.column_hits(column_hits),
		.last_row(last_row),
		.grid_invalid(grid_invalid)
	);

	function automatic longint floor_quot(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint clamp_cell(longint v, longint hi);
		if (v < 0)
			return 0;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Expected rows of one circle query, in doubled world units.
	task automatic predict_overlap(input logic signed [COORD_BITS-1:0] x,
			input logic signed [COORD_BITS-1:0] y, input logic signed [COORD_BITS-1:0] r);
		longint n, cs, cx2, cy2, r2, org2, span2;
		longint minx, maxx, miny, maxy, lox, hix, loy, hiy, qx, qy, dx, dy;
		row_result_t res;
		n = model_grid_count;
		cs = model_cell_size;
		if (n == 0 || cs == 0) begin
			res = '{row: 6'd0, hits: 64'd0, last: 1'b1, inv: 1'b1};
			expected_rows.push_back(res);
			return;
		end
		if (n > MAX_GRID)
			n = MAX_GRID;
		cx2 = 2 * longint'(x);
		cy2 = 2 * longint'(y);
		r2 = 2 * longint'(r);
		if (r2 < 0)
			r2 = 0;
		org2 = cs * n;
		span2 = 2 * cs;
		minx = clamp_cell(floor_quot(cx2 - r2 + org2, span2), n - 1);
		maxx = clamp_cell(floor_quot(cx2 + r2 + org2, span2), n - 1);
		miny = clamp_cell(floor_quot(cy2 - r2 + org2, span2), n - 1);
		maxy = clamp_cell(floor_quot(cy2 + r2 + org2, span2), n - 1);
		for (longint i = minx; i <= maxx; i++) begin
			res.hits = '0;
			lox = i * span2 - org2;
			hix = lox + span2;
			qx = cx2 < lox ? lox : (cx2 > hix ? hix : cx2);
			dx = qx > cx2 ? qx - cx2 : cx2 - qx;
			for (longint j = miny; j <= maxy; j++) begin
				loy = j * span2 - org2;
				hiy = loy + span2;
				qy = cy2 < loy ? loy : (cy2 > hiy ? hiy : cy2);
				dy = qy > cy2 ? qy - cy2 : cy2 - qy;
				if (dx <= r2 && dy <= r2 && dx * dx + dy * dy <= r2 * r2)
					res.hits[j] = 1'b1;
			end
			res.row = 6'(i);
			res.last = (i == maxx);
			res.inv = 1'b0;
			expected_rows.push_back(res);
		end
	endtask

	function automatic logic signed [COORD_BITS-1:0] fit_coord(longint v);
		if (v > 8388607)
			return 24'sd8388607;
		if (v < -8388608)
			return -24'sd8388608;
		return COORD_BITS'(v);
	endfunction

	function automatic logic signed [COORD_BITS-1:0] pick_coord(longint cs, longint n);
		int sel;
		longint half, span;
		sel = $urandom_range(99);
		half = cs * (n > MAX_GRID ? MAX_GRID : n) / 2;
		span = half + 2 * cs;
		if (sel < 10)
			return COORD_BITS'($urandom);
		if (sel < 14)
			return sel[0] ? 24'sd8388607 : -24'sd8388608;
		if (sel < 30)
			return fit_coord(longint'($urandom_range(0, 64)) * cs - half);
		return fit_coord(longint'($urandom_range(0, 32'(2 * span))) - span);
	endfunction

	function automatic logic signed [COORD_BITS-1:0] pick_radius(longint cs);
		int sel;
		sel = $urandom_range(99);
		if (sel < 5)
			return -COORD_BITS'($urandom_range(1, 8388608));
		if (sel < 10)
			return COORD_BITS'($urandom);
		if (sel < 16)
			return '0;
		return fit_coord($urandom_range(0, 32'(2 * cs)));
	endfunction

	task automatic add_query(input longint x, input longint y, input longint r,
			input int pct);
		request_t q;
		q = '{kind: OP_QUERY, cx: COORD_BITS'(x), cy: COORD_BITS'(y), rad: COORD_BITS'(r),
			idle_pct: pct, reg_idx: '0, reg_data: '0};
		pending_requests.push_back(q);
	endtask

	task automatic add_setting(input int cs, input int gc);
		request_t q;
		q = '{kind: OP_REG_WRITE, cx: '0, cy: '0, rad: '0, idle_pct: 0,
			reg_idx: 1'(REG_CELL_SIZE), reg_data: 16'(cs)};
		pending_requests.push_back(q);
		q.reg_idx = 1'(REG_GRID_COUNT);
		q.reg_data = 16'(gc);
		pending_requests.push_back(q);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Driver: issues queued requests, register writes only when the block is quiet.
	always @(posedge clk or negedge arst_n) begin
		request_t q;
		logic next_start;
		logic next_we;
		if (!arst_n) begin
			start <= 1'b0;
			center_x <= '0;
			center_y <= '0;
			radius <= '0;
			cfg_we <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
			quiet_cycles <= 0;
		end else begin
			next_start = start;
			next_we = 1'b0;
			if (start && !busy) begin
				predict_overlap(center_x, center_y, radius);
				next_start = 1'b0;
			end
			quiet_cycles <= (result_valid || start) ? 0 : quiet_cycles + 1;
			if (!next_start && pending_requests.size() > 0) begin
				q = pending_requests[0];
				case (q.kind)
					OP_QUERY: begin
						if ($urandom_range(99) >= q.idle_pct) begin
							center_x <= q.cx;
							center_y <= q.cy;
							radius <= q.rad;
							next_start = 1'b1;
							void'(pending_requests.pop_front());
						end
					end
					OP_REG_WRITE: begin
						if (!start && !busy && expected_rows.size() == 0
								&& quiet_cycles >= SETTLE) begin
							cfg_index <= q.reg_idx;
							cfg_data <= q.reg_data;
							next_we = 1'b1;
							if (q.reg_idx == 1'(REG_CELL_SIZE))
								model_cell_size = longint'(q.reg_data);
							else
								model_grid_count = longint'(q.reg_data[GC_W-1:0]);
							void'(pending_requests.pop_front());
						end
					end
					default: begin
						if (!start && expected_rows.size() == 0)
							void'(pending_requests.pop_front());
					end
				endcase
			end
			start <= next_start;
			cfg_we <= next_we;
		end
	end

	// Monitor: results are strobed for one cycle.
	always @(posedge clk) begin
		row_result_t e;
		if (arst_n && result_valid) begin
			if (expected_rows.size() == 0) begin
				$display("%0t: unexpected row result row=%0d hits=%h", $time, row_index,
					column_hits);
				errors++;
			end else begin
				e = expected_rows.pop_front();
				if (row_index !== e.row) begin
					$display("%0t: row_index exp %0d got %0d", $time, e.row, row_index);
					errors++;
				end
				if (column_hits !== e.hits) begin
					$display("%0t: column_hits exp %h got %h", $time, e.hits, column_hits);
					errors++;
				end
				if (last_row !== e.last) begin
					$display("%0t: last_row exp %b got %b", $time, e.last, last_row);
					errors++;
				end
				if (grid_invalid !== e.inv) begin
					$display("%0t: grid_invalid exp %b got %b", $time, e.inv, grid_invalid);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int phase_cs[9] = '{100, 1, 65535, 37, 7, 1000, 3, 250, 65535};
		int phase_gc[9] = '{16, 64, 64, 0, 33, 1, 2, 100, 1};
		int phase_pct[9] = '{0, 74, 0, 30, 74, 30, 0, 74, 30};
		request_t q;
		errors = 0;
		cycles = 0;
		model_cell_size = 100;
		model_grid_count = 16;
		arst_n = 1'b0;

		// Directed, reset settings: 16x16 cells of 100, grid edge at +/-800.
		add_query(0, 0, 0, 0);
		add_query(0, 0, 100, 0);
		add_query(800, 800, 0, 0);
		add_query(-800, -800, 0, 0);
		add_query(-801, 0, 0, 0);
		add_query(100, -100, 141, 0);
		add_query(100, -100, 142, 0);
		add_query(24'sd8388607, 24'sd8388607, 24'sd8388607, 0);
		add_query(-24'sd8388608, -24'sd8388608, -24'sd8388608, 0);
		add_query(-24'sd8388608, 24'sd8388607, 5, 0);
		add_query(5000, 5000, 10, 0);
		add_query(250, 250, -1, 0);
		add_query(-250, 30, 24'sd8388607, 0);
		add_query(50, 50, 49, 0);
		add_query(24'sh555555, 24'shAAAAAA, 24'sh0F0F0F, 0);
		q = '{kind: OP_DRAIN, cx: '0, cy: '0, rad: '0, idle_pct: 0, reg_idx: '0,
			reg_data: '0};
		pending_requests.push_back(q);
		// Odd grid count and the no-grid case.
		add_setting(10, 3);
		add_query(0, 0, 0, 0);
		add_query(-15, -15, 0, 0);
		add_query(15, 15, 5, 0);
		add_query(-16, 0, 0, 0);
		add_setting(10, 0);
		add_query(0, 0, 1, 0);

		for (int p = 0; p < 9; p++) begin
			add_setting(phase_cs[p], phase_gc[p]);
			for (int k = 0; k < 50; k++) begin
				add_query(pick_coord(phase_cs[p], phase_gc[p]),
					pick_coord(phase_cs[p], phase_gc[p]), pick_radius(phase_cs[p]),
					k < 10 ? 0 : phase_pct[p]);
				if (k == 25)
					pending_requests.push_back(q);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_requests.size() == 0 && !start);
		wait (expected_rows.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

FILE: sim.f
rtl/gcq_pkg.sv
rtl/gcq_ctrl.sv
rtl/gcq_dp.sv
rtl/grid_circle_cell_query.sv
test/tb_top.sv
